>>> hw/rtl/stfb_pkg.sv
// ----------------------------------------------------------------------------
// stfb_pkg
// Shared types and constants of the sync token frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package stfb_pkg;

  localparam int unsigned MaxPayloadDefault = 1023;
  localparam int unsigned CmdDepthDefault   = 4;
  localparam int unsigned StepW             = 3;

  localparam logic [7:0] SyncHi = 8'hDA;
  localparam logic [7:0] SyncLo = 8'hBA;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqData  = 1'b1;

  localparam logic [1:0] ChanInvalid = 2'd3;

  localparam logic [StepW-1:0] StepSync0 = 3'd0;
  localparam logic [StepW-1:0] StepSync1 = 3'd1;
  localparam logic [StepW-1:0] StepChan  = 3'd2;
  localparam logic [StepW-1:0] StepLenLo = 3'd3;
  localparam logic [StepW-1:0] StepLenHi = 3'd4;
  localparam logic [StepW-1:0] StepLenX  = 3'd5;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  channel_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       error;
    logic       last;
  } res_item_t;

  typedef enum logic [1:0] {
    CmdError,
    CmdStart,
    CmdData
  } cmd_kind_e;

  // One classified request; csum is the frame checksum if close is set.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  channel_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [7:0]  csum;
    logic        close;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/sync_token_frame_builder.sv
// ----------------------------------------------------------------------------
// sync_token_frame_builder
// Builds length-prefixed link frames with an XOR checksum, one byte a result.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// request   push / full      in_item_i  (req_type, channel_id, payload_length,
//                                        data_byte)
// result    pop / empty      res_item_o (tx_byte, frame_end, error, last)
//
// A request is classified in the cycle it is accepted and queued as a command
// (queue depth CMD_DEPTH). The back drains one result byte per cycle while the
// results are popped: a start gives 6 bytes (7 for zero length), a data byte 1
// (2 when it closes the frame), an error 1. Input stalls only while the command
// queue is full. Reset clears the frame state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_token_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = stfb_pkg::MaxPayloadDefault,
  parameter int unsigned CMD_DEPTH   = stfb_pkg::CmdDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire stfb_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output stfb_pkg::res_item_t     res_item_o
);
  import stfb_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;

  stfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (full),
    .item_i    (in_item_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  stfb_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  stfb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(~cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_item_o (res_item_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/stfb_front.sv
// ----------------------------------------------------------------------------
// stfb_front
// Accepts requests, checks them against the frame state and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module stfb_front #(
  parameter int unsigned MAX_PAYLOAD = stfb_pkg::MaxPayloadDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic              full_i,
  input  wire stfb_pkg::in_item_t item_i,
  output logic                   cmd_push_o,
  output stfb_pkg::cmd_t         cmd_o
);
  import stfb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);

  logic            open_q, open_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [7:0]      xor_q, xor_d;

  logic       accept;
  logic       len_bad;
  logic [7:0] hdr_x;
  logic [7:0] data_x;

  assign accept  = push_i & ~full_i;
  assign len_bad = {1'b0, item_i.payload_length} > 17'(MAX_PAYLOAD);
  // header bytes XOR: the two length bytes cancel against their XOR byte
  assign hdr_x   = SyncHi ^ SyncLo ^ {6'b0, item_i.channel_id};
  assign data_x  = xor_q ^ item_i.data_byte;

  always_comb begin
    open_d   = open_q;
    remain_d = remain_q;
    xor_d    = xor_q;
    cmd_o.kind           = CmdError;
    cmd_o.channel_id     = item_i.channel_id;
    cmd_o.payload_length = item_i.payload_length;
    cmd_o.data_byte      = item_i.data_byte;
    cmd_o.csum           = hdr_x;
    cmd_o.close          = 1'b0;
    if (item_i.req_type == ReqStart) begin
      if (item_i.channel_id != ChanInvalid && !len_bad) begin
        cmd_o.kind = CmdStart;
        if (item_i.payload_length == 16'd0) begin
          cmd_o.close = 1'b1;
          open_d      = 1'b0;
          remain_d    = '0;
          xor_d       = '0;
        end else begin
          open_d   = 1'b1;
          remain_d = item_i.payload_length[CntW-1:0];
          xor_d    = hdr_x;
        end
      end
    end else if (open_q && remain_q != '0) begin
      cmd_o.kind  = CmdData;
      cmd_o.csum  = data_x;
      remain_d    = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        cmd_o.close = 1'b1;
        open_d      = 1'b0;
        xor_d       = '0;
      end else begin
        xor_d = data_x;
      end
    end
  end

  assign cmd_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= '0;
      xor_q    <= '0;
    end else if (accept) begin
      open_q   <= open_d;
      remain_q <= remain_d;
      xor_q    <= xor_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stfb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// stfb_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stfb_cmd_fifo #(
  parameter int unsigned DEPTH = stfb_pkg::CmdDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire stfb_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output stfb_pkg::cmd_t     data_o,
  output logic               empty_o
);
  import stfb_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/stfb_back.sv
// ----------------------------------------------------------------------------
// stfb_back
// Expands commands into frame bytes and holds them in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stfb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire stfb_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output stfb_pkg::res_item_t res_item_o
);
  import stfb_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  res_item_t        out_q, res_d;
  logic             final_step;
  logic             load;

  always_comb begin
    res_d      = '0;
    final_step = 1'b0;
    case (cmd_i.kind)
      CmdStart: begin
        case (step_q)
          StepSync0: res_d.tx_byte = SyncHi;
          StepSync1: res_d.tx_byte = SyncLo;
          StepChan:  res_d.tx_byte = {6'b0, cmd_i.channel_id};
          StepLenLo: res_d.tx_byte = cmd_i.payload_length[7:0];
          StepLenHi: res_d.tx_byte = cmd_i.payload_length[15:8];
          StepLenX: begin
            res_d.tx_byte = cmd_i.payload_length[7:0] ^ cmd_i.payload_length[15:8];
            res_d.last    = cmd_i.close;
            final_step    = ~cmd_i.close;
          end
          default: begin
            // zero-length frame: checksum right after the header
            res_d.tx_byte   = cmd_i.csum;
            res_d.frame_end = 1'b1;
            res_d.last      = 1'b1;
            final_step      = 1'b1;
          end
        endcase
      end
      CmdData: begin
        if (step_q == StepSync0) begin
          res_d.tx_byte = cmd_i.data_byte;
          res_d.last    = ~cmd_i.close;
          final_step    = ~cmd_i.close;
        end else begin
          res_d.tx_byte   = cmd_i.csum;
          res_d.frame_end = 1'b1;
          res_d.last      = 1'b1;
          final_step      = 1'b1;
        end
      end
      default: begin
        res_d.error = 1'b1;
        res_d.last  = 1'b1;
        final_step  = 1'b1;
      end
    endcase
  end

  // advance when the result register is free or being drained
  assign load        = cmd_valid_i & (~out_valid_q | pop_i);
  assign cmd_pop_o   = load & final_step;
  assign out_valid_d = load | (out_valid_q & ~pop_i);
  assign step_d      = final_step ? '0 : step_q + StepW'(1);
  assign empty_o     = ~out_valid_q;
  assign res_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res_d;
  end

endmodule

`default_nettype wire

>>> verif/sync_token_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// sync_token_frame_builder_tb
// Self-checking bench for the frame builder. Requests go in through the
// push/full queue port and a frame-byte model predicts every result byte:
// header, payload, checksum and error results. Results are drained through
// empty/pop and compared in order. Both sides stall at random. A long result
// hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module sync_token_frame_builder_tb;
  import stfb_pkg::*;

  localparam int unsigned MaxPayload   = MaxPayloadDefault;
  localparam int unsigned RandomItems  = 240;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned EndWait      = 20;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned InItemW      = $bits(in_item_t);

  localparam logic [1:0] ChanConsole = 2'd0;
  localparam logic [1:0] ChanPixel   = 2'd1;
  localparam logic [1:0] ChanFill    = 2'd2;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item  = '0;
  res_item_t res_item;

  // Frame state of the byte model
  logic       frame_open   = 1'b0;
  logic [9:0] payload_left = '0;
  logic [7:0] frame_xor    = '0;

  res_item_t tx_expect_q[$];

  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  logic        hold_trigger = 1'b0;
  logic        steady_flow  = 1'b0;

  sync_token_frame_builder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .res_item_o (res_item)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Frame byte model
  function automatic void queue_tx_byte(logic [7:0] b, logic fend, logic err, logic lst);
    res_item_t r;
    r.tx_byte   = b;
    r.frame_end = fend;
    r.error     = err;
    r.last      = lst;
    tx_expect_q.push_back(r);
  endfunction

  function automatic void predict_tx_bytes(in_item_t it);
    logic [7:0] hdr [6];
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    if (it.req_type == ReqStart) begin
      if (it.channel_id == ChanInvalid || it.payload_length > MaxPayload) begin
        queue_tx_byte(8'h00, 1'b0, 1'b1, 1'b1);
        return;
      end
      len_lo = it.payload_length[7:0];
      len_hi = it.payload_length[15:8];
      hdr[0] = SyncHi;
      hdr[1] = SyncLo;
      hdr[2] = {6'd0, it.channel_id};
      hdr[3] = len_lo;
      hdr[4] = len_hi;
      hdr[5] = len_lo ^ len_hi;
      frame_xor = '0;
      for (int i = 0; i < 6; i++) begin
        frame_xor ^= hdr[i];
        queue_tx_byte(hdr[i], 1'b0, 1'b0, (i == 5) && (it.payload_length == 0));
      end
      if (it.payload_length == 0) begin
        queue_tx_byte(frame_xor, 1'b1, 1'b0, 1'b1);
        frame_open   = 1'b0;
        payload_left = '0;
        frame_xor    = '0;
      end else begin
        frame_open   = 1'b1;
        payload_left = it.payload_length[9:0];
      end
      return;
    end
    if (!frame_open || payload_left == 0) begin
      queue_tx_byte(8'h00, 1'b0, 1'b1, 1'b1);
      return;
    end
    frame_xor ^= it.data_byte;
    payload_left--;
    if (payload_left == 0) begin
      queue_tx_byte(it.data_byte, 1'b0, 1'b0, 1'b0);
      queue_tx_byte(frame_xor, 1'b1, 1'b0, 1'b1);
      frame_open = 1'b0;
      frame_xor  = '0;
    end else begin
      queue_tx_byte(it.data_byte, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic in_item_t start_req(logic [1:0] chan, logic [15:0] len);
    in_item_t it;
    it                = InItemW'($urandom);
    it.req_type       = ReqStart;
    it.channel_id     = chan;
    it.payload_length = len;
    return it;
  endfunction

  function automatic in_item_t data_req(logic [7:0] b);
    in_item_t it;
    it           = InItemW'($urandom);
    it.req_type  = ReqData;
    it.data_byte = b;
    return it;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Send one request; push stays high after acceptance so back-to-back
  // requests need no extra edge.
  task automatic send_req(in_item_t it);
    while (!steady_flow && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    predict_tx_bytes(it);
  endtask

  // Drop push and hold until every predicted byte has been popped
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (tx_expect_q.size() != 0);
  endtask

  // Result side: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_trigger) begin
      hold_left <= HoldCycles;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= steady_flow || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && pop && !empty) begin
      if (tx_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected result tx_byte=%02h frame_end=%0b error=%0b last=%0b",
                               res_item.tx_byte, res_item.frame_end, res_item.error,
                               res_item.last));
      end else begin
        want = tx_expect_q.pop_front();
        if (res_item.tx_byte !== want.tx_byte || res_item.frame_end !== want.frame_end ||
            res_item.error !== want.error || res_item.last !== want.last) begin
          note_failure($sformatf(
            "got tx_byte=%02h frame_end=%0b error=%0b last=%0b, want %02h %0b %0b %0b",
            res_item.tx_byte, res_item.frame_end, res_item.error, res_item.last,
            want.tx_byte, want.frame_end, want.error, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_errors_after_reset();
    send_req(data_req(8'hFF));
    send_req(data_req(8'h00));
    send_req(start_req(ChanInvalid, 16'd4));
    send_req(start_req(ChanConsole, 16'd1024));
    send_req(start_req(ChanPixel, 16'hFFFF));
    send_req(start_req(ChanInvalid, 16'hFFFF));
    drain_results();
  endtask

  task automatic test_zero_length();
    send_req(start_req(ChanConsole, 16'd0));
    send_req(start_req(ChanFill, 16'd0));
    send_req(data_req(8'h5A));
    drain_results();
  endtask

  task automatic test_short_frames();
    send_req(start_req(ChanPixel, 16'd1));
    send_req(data_req(8'hFF));
    send_req(start_req(ChanFill, 16'd3));
    send_req(data_req(8'h00));
    send_req(data_req(8'hA5));
    send_req(data_req(8'h5A));
    send_req(data_req(8'h11));
    drain_results();
  endtask

  // Bad starts leave the open frame alone; a good start abandons it
  task automatic test_start_inside_frame();
    send_req(start_req(ChanConsole, 16'(MaxPayload)));
    send_req(data_req(8'h3C));
    send_req(start_req(ChanInvalid, 16'd2));
    send_req(start_req(ChanFill, 16'd1024));
    send_req(data_req(8'hC3));
    send_req(start_req(ChanPixel, 16'd2));
    send_req(data_req(8'h80));
    send_req(data_req(8'h01));
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_trigger <= 1'b1;
    @(posedge clk_i);
    hold_trigger <= 1'b0;
    send_req(start_req(ChanFill, 16'd12));
    for (int k = 0; k < 12; k++) send_req(data_req(8'($urandom)));
    send_req(data_req(8'($urandom)));
    send_req(start_req(ChanInvalid, 16'($urandom)));
    send_req(start_req(ChanConsole, 16'd0));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [1:0]  chan;
    sent = 0;
    while (sent < RandomItems) begin
      steady_flow <= (sent >= 100 && sent < 180);
      chan = 2'($urandom_range(ChanConsole, ChanFill));
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 96) : $urandom_range(0, 10);
        send_req(start_req(chan, 16'(len)));
        sent++;
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            send_req(start_req(ChanInvalid, 16'($urandom)));
            sent++;
          end else if (pick < 5) begin
            break;
          end
          send_req(data_req(8'($urandom)));
          sent++;
        end
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: send_req(data_req(8'($urandom)));
          1: send_req(start_req(ChanInvalid, 16'($urandom)));
          2: send_req(start_req(chan, 16'($urandom_range(MaxPayload + 1, 16'hFFFF))));
          default: send_req(in_item_t'(InItemW'($urandom)));
        endcase
        sent++;
      end
    end
    steady_flow <= 1'b0;
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_errors_after_reset();
    test_zero_length();
    test_short_frames();
    test_start_inside_frame();
    test_backpressure();
    test_random_traffic();
    repeat (EndWait) @(posedge clk_i);
    if (fail_count == 0 && tx_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
